// ----- rtl/gha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS     = 256;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int GEN_W     = 8;
  localparam int ITEM_W    = 32;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;
  localparam logic [CNT_W-1:0] UNMAPPED = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] THRESH_RESET = 9'd16;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] handle_slot;
    logic [GEN_W-1:0]  handle_gen;
    logic [ITEM_W-1:0] item_word;
    logic [SLOT_W-1:0] dense_pos;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] out_slot;
    logic [GEN_W-1:0]  out_gen;
    logic [ITEM_W-1:0] out_item;
    logic [CNT_W-1:0]  live_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request
    logic rd1;    // issue first table reads
    logic rd2;    // issue dependent reads
    logic commit; // perform writes and emit result
  } ctl_t;

endpackage

// ----- rtl/gha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: idle, two read phases, commit.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output gha_pkg::ctl_t ctl
);
  import gha_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_COM  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_COM;
      S_COM:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy       = (state != S_IDLE);
  assign ctl.load   = (state == S_IDLE) && start;
  assign ctl.rd1    = (state == S_RD1);
  assign ctl.rd2    = (state == S_RD2);
  assign ctl.commit = (state == S_COM);

`ifndef SYNTHESIS
  a_seq: assert property (@(posedge clk) disable iff (rst) ctl.rd1 |=> ctl.rd2)
    else $error("rd2 must follow rd1");
  a_com: assert property (@(posedge clk) disable iff (rst) ctl.rd2 |=> ctl.commit)
    else $error("commit must follow rd2");
  a_idle: assert property (@(posedge clk) disable iff (rst) ctl.commit |=> !busy)
    else $error("idle after commit");
`endif

endmodule

// ----- rtl/gha_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_dp
// Tables, free queue, counters and result register.
// ----------------------------------------------------------------------------
module gha_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  gha_pkg::ctl_t          ctl,
  input  gha_pkg::req_t          req,
  input  logic                   cfg_we,
  input  logic [gha_pkg::CNT_W-1:0] cfg_wdata,
  output gha_pkg::rsp_t          rsp,
  output logic                   rsp_valid
);
  import gha_pkg::*;

  logic [GEN_W-1:0]  gen_mem   [SLOTS];
  logic [CNT_W-1:0]  s2d_mem   [SLOTS];
  logic [ITEM_W-1:0] item_mem  [SLOTS];
  logic [SLOT_W-1:0] owner_mem [SLOTS];
  logic [SLOT_W-1:0] fifo_mem  [SLOTS];

  logic [CNT_W-1:0]  thresh;
  logic [SLOT_W-1:0] free_head, free_tail;
  logic [CNT_W-1:0]  free_level, slots_opened, live;
  req_t              r;

  // phase-1 read data
  logic [SLOT_W-1:0] fifo_q;
  logic [GEN_W-1:0]  gen_q;
  logic [CNT_W-1:0]  s2d_q;
  logic [ITEM_W-1:0] item_q;     // read: item at pos
  logic [SLOT_W-1:0] last_owner_q;
  logic [ITEM_W-1:0] last_item_q;
  // phase-2 read data
  logic [GEN_W-1:0]  gen2_q;
  logic [SLOT_W-1:0] idx_owner_q;
  logic [ITEM_W-1:0] idx_item_q;

  logic [CNT_W-1:0]  last;
  logic              can_open, reuse;
  logic [SLOT_W-1:0] new_slot;
  logic              rm_ok;
  logic [GEN_W-1:0]  new_gen;
  rsp_t              rsp_next;

  // unmap of removed slot when it was not the last entry
  logic              unmap_pend;
  logic [SLOT_W-1:0] unmap_slot;

  assign last     = live - 1'b1;
  assign can_open = slots_opened < UNMAPPED;
  assign reuse    = (free_level != '0) && ((free_level > thresh) || !can_open);

  // phase 1: reads addressed by the request and counters; phase 2: reads addressed by phase-1 data
  always_ff @(posedge clk) begin
    if (ctl.rd1) begin
      fifo_q       <= fifo_mem[free_head];
      gen_q        <= gen_mem[r.handle_slot];
      s2d_q        <= s2d_mem[r.handle_slot];
      item_q       <= item_mem[r.dense_pos];
      last_owner_q <= owner_mem[last[SLOT_W-1:0]];
      last_item_q  <= item_mem[last[SLOT_W-1:0]];
    end
    if (ctl.rd2) begin
      gen2_q      <= gen_mem[fifo_q];
      idx_owner_q <= owner_mem[s2d_q[SLOT_W-1:0]];
      idx_item_q  <= item_mem[s2d_q[SLOT_W-1:0]];
    end
  end

  assign new_slot = reuse ? fifo_q : slots_opened[SLOT_W-1:0];
  assign new_gen  = reuse ? gen2_q + 1'b1 : '0;
  assign rm_ok    = ({1'b0, r.handle_slot} < slots_opened) && (gen_q == r.handle_gen)
                    && (s2d_q < live) && (idx_owner_q == r.handle_slot);

  always_comb begin
    rsp_next = '0;
    rsp_next.live_count = live;
    case (r.cmd)
      CMD_CREATE: begin
        if (reuse || can_open) begin
          rsp_next.out_slot   = new_slot;
          rsp_next.out_gen    = new_gen;
          rsp_next.live_count = live + 1'b1;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (rm_ok) begin
          rsp_next.out_item   = idx_item_q;
          rsp_next.live_count = last;
        end else begin
          rsp_next.status = ST_STALE;
        end
      end
      CMD_READ: begin
        if ({1'b0, r.dense_pos} < live) rsp_next.out_item = item_q;
        else rsp_next.status = ST_RANGE;
      end
      default: rsp_next.live_count = live;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) unmap_pend <= 1'b0;
    else unmap_pend <= ctl.commit && r.cmd == CMD_REMOVE && rm_ok
                       && last_owner_q != r.handle_slot;
    unmap_slot <= r.handle_slot;
  end

  // commit writes; the deferred unmap lands the cycle after a commit, so it
  // never meets another table write
  always_ff @(posedge clk) begin
    if (unmap_pend) s2d_mem[unmap_slot] <= UNMAPPED;
    if (ctl.commit) begin
      if (r.cmd == CMD_CREATE && (reuse || can_open)) begin
        gen_mem[new_slot]              <= new_gen;
        item_mem[live[SLOT_W-1:0]]     <= r.item_word;
        owner_mem[live[SLOT_W-1:0]]    <= new_slot;
        s2d_mem[new_slot]              <= live;
      end else if (r.cmd == CMD_REMOVE && rm_ok) begin
        item_mem[s2d_q[SLOT_W-1:0]]  <= last_item_q;
        owner_mem[s2d_q[SLOT_W-1:0]] <= last_owner_q;
        if (last_owner_q == r.handle_slot) s2d_mem[r.handle_slot] <= UNMAPPED;
        else begin
          s2d_mem[last_owner_q] <= s2d_q;
        end
        if (gen_q != GEN_MAX && free_level < UNMAPPED) fifo_mem[free_tail] <= r.handle_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh       <= THRESH_RESET;
      free_head    <= '0;
      free_tail    <= '0;
      free_level   <= '0;
      slots_opened <= '0;
      live         <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) thresh <= cfg_wdata;
      rsp_valid <= ctl.commit;
      if (ctl.load) r <= req;
      if (ctl.commit) begin
        rsp <= rsp_next;
        case (r.cmd)
          CMD_CREATE: begin
            if (reuse || can_open) begin
              if (reuse) begin
                free_head  <= free_head + 1'b1;
                free_level <= free_level - 1'b1;
              end else begin
                slots_opened <= slots_opened + 1'b1;
              end
              live <= live + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (rm_ok) begin
              live <= last;
              if (gen_q != GEN_MAX && free_level < UNMAPPED) begin
                free_tail  <= free_tail + 1'b1;
                free_level <= free_level + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_lvl: assert property (@(posedge clk) disable iff (rst) free_level <= UNMAPPED)
    else $error("free level overflow");
  a_live: assert property (@(posedge clk) disable iff (rst) live <= slots_opened)
    else $error("live exceeds opened slots");
  a_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.live_count == live))
    else $error("live count mismatch");
`endif

endmodule

// ----- rtl/generational_handle_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot map of generational handles over a packed item array.
// ----------------------------------------------------------------------------
// channel   | ports                      | handshake
// request   | start, busy, req           | taken when start && !busy
// result    | done, rsp                  | one-cycle strobe, no backpressure
// config    | cfg_we, cfg_wdata          | written when cfg_we
// Each request runs capture, two dependent table reads and commit in turn;
// result strobes the cycle after commit, busy drops then too. The unmap
// write of a remove is made while the result strobes, before any next read.
// Synchronous reset clears counters; tables need no clearing.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  gha_pkg::req_t             req,
  input  logic                      cfg_we,
  input  logic [gha_pkg::CNT_W-1:0] cfg_wdata,
  output logic                      done,
  output gha_pkg::rsp_t             rsp
);
  import gha_pkg::*;

  ctl_t ctl;

  gha_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .ctl(ctl));

  gha_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req(req), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .rsp(rsp), .rsp_valid(done)
  );

endmodule

// ----- dv/gha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_checker
// Watches the request, result and config channels of the handle allocator,
// keeps its own slot map model, predicts one response per accepted request
// and compares every response field by field, in order.
// ----------------------------------------------------------------------------
module gha_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  gha_pkg::req_t             req,
  input  logic                      cfg_we,
  input  logic [gha_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      done,
  input  gha_pkg::rsp_t             rsp,
  output int                        errors,
  output int                        pending
);
  import gha_pkg::*;

  logic [CNT_W-1:0]  reuse_thresh;
  logic [GEN_W-1:0]  gen_of   [SLOTS];
  logic [CNT_W-1:0]  dense_of [SLOTS];
  logic [ITEM_W-1:0] items    [SLOTS];
  logic [SLOT_W-1:0] owner    [SLOTS];
  logic [SLOT_W-1:0] free_q   [SLOTS];
  logic [SLOT_W-1:0] free_rd, free_wr;
  logic [CNT_W-1:0]  free_cnt, opened, live;

  rsp_t expected_rsps[$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic rsp_t allocate(logic [ITEM_W-1:0] word);
    rsp_t r;
    logic [SLOT_W-1:0] s;
    r = '0;
    if (free_cnt != 0 && (free_cnt > reuse_thresh || opened == SLOTS)) begin
      s = free_q[free_rd];
      free_rd++;
      free_cnt--;
      gen_of[s] = gen_of[s] + 1'b1;
    end else if (opened < SLOTS) begin
      s = opened[SLOT_W-1:0];
      opened++;
      gen_of[s] = '0;
    end else begin
      r.status = ST_FULL;
      r.live_count = live;
      return r;
    end
    items[live[SLOT_W-1:0]] = word;
    owner[live[SLOT_W-1:0]] = s;
    dense_of[s] = live;
    live++;
    r.out_slot = s;
    r.out_gen = gen_of[s];
    r.live_count = live;
    return r;
  endfunction

  function automatic rsp_t release_handle(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    rsp_t r;
    logic [CNT_W-1:0]  idx;
    logic [SLOT_W-1:0] last, moved;
    r = '0;
    if (s >= opened || gen_of[s] != g || dense_of[s] >= live ||
        owner[dense_of[s][SLOT_W-1:0]] != s) begin
      r.status = ST_STALE;
      r.live_count = live;
      return r;
    end
    idx = dense_of[s];
    r.out_item = items[idx[SLOT_W-1:0]];
    last = SLOT_W'(live - 1);
    moved = owner[last];
    items[idx[SLOT_W-1:0]] = items[last];
    owner[idx[SLOT_W-1:0]] = moved;
    dense_of[moved] = idx;
    dense_of[s] = UNMAPPED;
    live--;
    if (gen_of[s] != GEN_MAX && free_cnt < SLOTS) begin
      free_q[free_wr] = s;
      free_wr++;
      free_cnt++;
    end
    r.live_count = live;
    return r;
  endfunction

  function automatic rsp_t predict_rsp(req_t q);
    rsp_t r;
    r = '0;
    case (q.cmd)
      CMD_CREATE: r = allocate(q.item_word);
      CMD_REMOVE: r = release_handle(q.handle_slot, q.handle_gen);
      CMD_READ: begin
        if (q.dense_pos >= live) begin
          r.status = ST_RANGE;
        end else begin
          r.out_item = items[q.dense_pos];
        end
        r.live_count = live;
      end
      default: r.live_count = live;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rsp_t w;
    if (rst) begin
      reuse_thresh <= THRESH_RESET;
      free_rd = '0;
      free_wr = '0;
      free_cnt = '0;
      opened = '0;
      live = '0;
      expected_rsps.delete();
    end else begin
      if (cfg_we) reuse_thresh <= cfg_wdata;
      if (done) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 32'(rsp), 32'd0);
        end else begin
          w = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp.status !== w.status)
            report("status", 32'(rsp.status), 32'(w.status));
          if (rsp.out_slot !== w.out_slot)
            report("out_slot", 32'(rsp.out_slot), 32'(w.out_slot));
          if (rsp.out_gen !== w.out_gen)
            report("out_gen", 32'(rsp.out_gen), 32'(w.out_gen));
          if (rsp.out_item !== w.out_item) report("out_item", rsp.out_item, w.out_item);
          if (rsp.live_count !== w.live_count)
            report("live_count", 32'(rsp.live_count), 32'(w.live_count));
        end
      end
      if (start && !busy) expected_rsps.insert(expected_rsps.size(), predict_rsp(req));
    end
    pending = expected_rsps.size();
  end

endmodule

// ----- dv/generational_handle_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_core_test
// Drives create, remove, read and unused commands through several reuse
// thresholds: directed corners, generation wrap to retirement, table full,
// then random mixed traffic with random gaps. The checker predicts/compares.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core_test;
  import gha_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int LIMIT = 200000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  logic             clk = 0;
  logic             rst = 1;
  logic             start = 0;
  logic             busy;
  req_t             req = '0;
  logic             cfg_we = 0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             done;
  rsp_t             rsp;
  int               errors, pending;
  int               cycles = 0;
  bit               no_gaps = 0;

  handle_t   live_handles[$];
  handle_t   dead_handles[$];
  logic [1:0] issued_cmds[$];

  always #4 clk = ~clk;

  generational_handle_allocator_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp)
  );

  gha_checker i_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // learn handles from create responses
  always @(posedge clk) begin
    handle_t h;
    logic [1:0] c;
    if (!rst && done && issued_cmds.size() != 0) begin
      c = issued_cmds[0];
      issued_cmds.delete(0);
      if (c == CMD_CREATE && rsp.status == ST_OK) begin
        h.slot = rsp.out_slot;
        h.gen = rsp.out_gen;
        live_handles.insert(live_handles.size(), h);
      end
    end
  end

  task automatic issue(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    req = r;
    do @(posedge clk); while (busy);
    issued_cmds.insert(issued_cmds.size(), r.cmd);
    @(negedge clk);
    if ($urandom_range(0, 63) == 0) no_gaps = ~no_gaps;
  endtask

  task automatic wait_idle();
    start = 0;
    while (pending != 0 || issued_cmds.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_thresh(logic [CNT_W-1:0] v);
    wait_idle();
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic req_t noise_req();
    req_t r;
    r.cmd = 2'($urandom_range(0, 3));
    r.handle_slot = 8'($urandom);
    r.handle_gen = 8'($urandom);
    r.item_word = $urandom;
    r.dense_pos = 8'($urandom);
    return r;
  endfunction

  task automatic create(logic [ITEM_W-1:0] w);
    req_t r;
    r = noise_req();
    r.cmd = CMD_CREATE;
    r.item_word = w;
    issue(r);
  endtask

  task automatic remove(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    req_t r;
    r = noise_req();
    r.cmd = CMD_REMOVE;
    r.handle_slot = s;
    r.handle_gen = g;
    issue(r);
  endtask

  task automatic read(logic [SLOT_W-1:0] p);
    req_t r;
    r = noise_req();
    r.cmd = CMD_READ;
    r.dense_pos = p;
    issue(r);
  endtask

  task automatic random_traffic(int n);
    int k, pick, idx;
    handle_t h;
    req_t r;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        create($urandom);
      end else if (pick < 75) begin
        if (live_handles.size() != 0 && $urandom_range(0, 9) < 8) begin
          idx = $urandom_range(0, live_handles.size() - 1);
          h = live_handles[idx];
          live_handles.delete(idx);
          dead_handles.insert(dead_handles.size(), h);
          remove(h.slot, h.gen);
        end else if (dead_handles.size() != 0 && $urandom_range(0, 1) == 1) begin
          h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
          remove(h.slot, h.gen);
        end else begin
          remove(8'($urandom), 8'($urandom));
        end
      end else if (pick < 95) begin
        if ($urandom_range(0, 9) < 8)
          read(8'($urandom_range(0, live_handles.size() + 1) > 255 ? 255 :
                    $urandom_range(0, live_handles.size() + 1)));
        else
          read(8'($urandom));
      end else begin
        r = noise_req();
        r.cmd = CMD_NONE;
        issue(r);
      end
    end
  endtask

  initial begin
    handle_t h;
    repeat (6) @(negedge clk);
    rst = 0;

    // directed corners at the reset threshold
    read(8'd0);
    remove(8'd0, 8'd0);
    create(32'h0000_0000);
    create(32'hFFFF_FFFF);
    create(32'hA5A5_5A5A);
    read(8'd0);
    read(8'd2);
    read(8'd3);
    read(8'd255);
    remove(8'd0, 8'hFF);
    remove(8'd255, 8'd0);
    begin
      req_t r;
      r = noise_req();
      r.cmd = CMD_NONE;
      issue(r);
    end
    wait_idle();
    h = live_handles[0];
    live_handles.delete(0);
    remove(h.slot, h.gen);
    remove(h.slot, h.gen);
    dead_handles.insert(dead_handles.size(), h);
    h = live_handles.pop_back();
    remove(h.slot, h.gen);
    dead_handles.insert(dead_handles.size(), h);
    read(8'd0);
    read(8'd1);

    // immediate reuse: wrap one slot's generation until it retires
    write_thresh(9'd0);
    repeat (3) create($urandom);
    for (int k = 0; k < 262; k++) begin
      create($urandom);
      wait_idle();
      h = live_handles.pop_back();
      remove(h.slot, h.gen);
      if ($urandom_range(0, 15) == 0) dead_handles.insert(dead_handles.size(), h);
    end

    // never reuse until forced: fill the table past full
    write_thresh(9'd256);
    repeat (270) create($urandom);
    wait_idle();
    random_traffic(300);

    write_thresh(9'd7);
    random_traffic(330);
    write_thresh(9'd0);
    random_traffic(330);

    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gha_pkg.sv
rtl/gha_ctrl.sv
rtl/gha_dp.sv
rtl/generational_handle_allocator_core.sv
dv/gha_checker.sv
dv/generational_handle_allocator_core_test.sv
